### src/ptpm_pkg.sv
// shared constants, codes and controller/datapath interface types for the
// priority table with promote and pop-max; no dependencies
package ptpm_pkg;

  localparam int SLOTS          = 64;
  localparam int PAYLOAD_WIDTH  = 32;
  localparam int PRIORITY_WIDTH = 16;
  localparam int SEQ_W          = 32;
  localparam int IDX_W          = $clog2(SLOTS);
  localparam int ENTRY_W        = SEQ_W + PRIORITY_WIDTH + PAYLOAD_WIDTH;

  // fixed field widths of the item and result
  localparam int OP_W       = 3;
  localparam int HANDLE_W   = 6;
  localparam int PAY_IO_W   = 32;
  localparam int PRIO_OUT_W = 16;
  localparam int STATUS_W   = 2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_USED_W  = STATUS_W + HANDLE_W + PAY_IO_W + PRIO_OUT_W + 1;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_ADD      = 3'd0;
  localparam op_t OP_PROMOTE  = 3'd1;
  localparam op_t OP_POP_MAX  = 3'd2;
  localparam op_t OP_GET_MAX  = 3'd3;
  localparam op_t OP_IS_VALID = 3'd4;
  localparam op_t OP_GET      = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_BAD   = 2'd3;

  typedef struct packed {
    logic accept;    // latch the incoming item
    logic cnt_inc;   // advance slot counter
    logic add_take;  // claim the slot under the counter
    logic rd_h;      // read table entry at the item handle
    logic rd_cnt;    // read table entry at the counter (max scan)
    logic grab;      // capture read data as the result entry
    logic prom_wr;   // write back incremented priority
    logic load_out;  // move the result into the output register
  } ptpm_cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic in_live;
    op_t  op;
    logic cnt_last;
    logic cnt_free;
    logic out_free;
  } ptpm_sts_t;

endpackage

### src/ptpm_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module ptpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/ptpm_dp.sv
// datapath: valid bits, entry ram, scan compare, result and output register
// depends on ptpm_pkg and ptpm_ram
module ptpm_dp
  import ptpm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  ptpm_cmd_t              cmd,
  output ptpm_sts_t              sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  op_t                       in_op;
  logic [HANDLE_W-1:0]       in_h;
  logic [PAY_IO_W-1:0]       in_pl;
  logic                      in_live;

  logic [SLOTS-1:0]          valid_r;
  logic [SEQ_W-1:0]          next_seq_r;
  op_t                       op_r;
  logic [HANDLE_W-1:0]       h_r;
  logic [PAYLOAD_WIDTH-1:0]  pl_r;
  logic [IDX_W-1:0]          cnt_r;
  logic                      found_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic [PRIORITY_WIDTH-1:0] best_pr_r;
  logic [SEQ_W-1:0]          best_seq_r;
  logic [PAYLOAD_WIDTH-1:0]  best_pl_r;
  logic                      dv_r;
  logic                      dvld_r;
  logic [IDX_W-1:0]          didx_r;
  logic                      out_valid_r;
  logic [OUT_TDATA_W-1:0]    out_data_r;

  logic [IDX_W-1:0]          h_idx;
  logic                      ram_we;
  logic                      ram_re;
  logic [IDX_W-1:0]          ram_waddr;
  logic [IDX_W-1:0]          ram_raddr;
  logic [ENTRY_W-1:0]        ram_wdata;
  logic [ENTRY_W-1:0]        ram_rdata;
  logic [SEQ_W-1:0]          rd_seq;
  logic [PRIORITY_WIDTH-1:0] rd_pr;
  logic [PAYLOAD_WIDTH-1:0]  rd_pl;
  logic [PRIORITY_WIDTH-1:0] pr_inc;
  logic                      better;

  status_t                   res_st;
  logic [HANDLE_W-1:0]       res_h;
  logic [PAY_IO_W-1:0]       res_pl;
  logic [PRIO_OUT_W-1:0]     res_pr;
  logic                      res_v;

  // input item: opcode, handle, payload from the lowest bit up
  assign in_op   = in_tdata[2:0];
  assign in_h    = in_tdata[8:3];
  assign in_pl   = in_tdata[40:9];
  assign in_live = (32'(in_h) < 32'(SLOTS)) && valid_r[IDX_W'(in_h)];

  assign h_idx = IDX_W'(h_r);

  assign {rd_seq, rd_pr, rd_pl} = ram_rdata;
  // saturating increment
  assign pr_inc = (rd_pr == '1) ? rd_pr : rd_pr + 1'b1;

  assign ram_re    = cmd.rd_cnt | cmd.rd_h;
  assign ram_raddr = cmd.rd_cnt ? cnt_r : h_idx;
  assign ram_we    = cmd.add_take | cmd.prom_wr;
  assign ram_waddr = cmd.add_take ? cnt_r : h_idx;
  assign ram_wdata = cmd.add_take ? {next_seq_r, {PRIORITY_WIDTH{1'b0}}, pl_r}
                                  : {rd_seq, pr_inc, rd_pl};

  ptpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // higher priority wins, then higher sequence; equal keeps the lower slot
  assign better = dvld_r &&
                  (!found_r || (rd_pr > best_pr_r) ||
                   ((rd_pr == best_pr_r) && (rd_seq > best_seq_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      next_seq_r  <= '0;
      found_r     <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dv_r <= cmd.rd_cnt;
      if (cmd.accept) begin
        found_r <= in_live && ((in_op == OP_PROMOTE) || (in_op == OP_GET) ||
                               (in_op == OP_IS_VALID));
      end else if (cmd.add_take || (dv_r && better)) begin
        found_r <= 1'b1;
      end
      if (cmd.add_take) begin
        valid_r[cnt_r] <= 1'b1;
        next_seq_r     <= next_seq_r + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        if ((op_r == OP_POP_MAX) && found_r) begin
          valid_r[best_idx_r] <= 1'b0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvld_r <= valid_r[cnt_r];
    didx_r <= cnt_r;
    if (cmd.accept) begin
      op_r  <= in_op;
      h_r   <= in_h;
      pl_r  <= PAYLOAD_WIDTH'(in_pl);
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.add_take) begin
      best_idx_r <= cnt_r;
    end else if (dv_r && better) begin
      best_idx_r <= didx_r;
      best_pr_r  <= rd_pr;
      best_seq_r <= rd_seq;
      best_pl_r  <= rd_pl;
    end
    if (cmd.grab) begin
      best_pr_r <= cmd.prom_wr ? pr_inc : rd_pr;
      best_pl_r <= rd_pl;
    end
    if (cmd.load_out) begin
      out_data_r <= {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                     res_v, res_pr, res_pl, res_h, res_st};
    end
  end

  always_comb begin
    res_st = ST_OK;
    res_h  = '0;
    res_pl = '0;
    res_pr = '0;
    res_v  = 1'b0;
    case (op_r)
      OP_ADD: begin
        res_st = found_r ? ST_OK : ST_FULL;
        res_h  = found_r ? HANDLE_W'(best_idx_r) : '0;
      end
      OP_PROMOTE, OP_GET: begin
        res_h = h_r;
        if (found_r) begin
          res_pl = PAY_IO_W'(best_pl_r);
          res_pr = PRIO_OUT_W'(best_pr_r);
          res_v  = 1'b1;
        end else begin
          res_st = ST_BAD;
        end
      end
      OP_POP_MAX, OP_GET_MAX: begin
        if (found_r) begin
          res_h  = HANDLE_W'(best_idx_r);
          res_pl = PAY_IO_W'(best_pl_r);
          res_pr = PRIO_OUT_W'(best_pr_r);
        end else begin
          res_st = ST_EMPTY;
        end
      end
      OP_IS_VALID: begin
        res_h = h_r;
        res_v = found_r;
      end
      default: begin
        res_st = ST_OK;
      end
    endcase
  end

  assign sts.in_op    = in_op;
  assign sts.in_live  = in_live;
  assign sts.op       = op_r;
  assign sts.cnt_last = (cnt_r == IDX_W'(SLOTS - 1));
  assign sts.cnt_free = !valid_r[cnt_r];
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // add only ever claims a free slot
  a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_take |-> !valid_r[cnt_r])
    else $error("add claimed a live slot");

  // each claimed slot consumes exactly one sequence number
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_take |=> (next_seq_r == $past(next_seq_r) + 1'b1))
    else $error("sequence did not advance on add");

  // a result is never loaded over one that is still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("output register overrun");

  // a scan compare only follows a scan read
  a_scan_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> $past(cmd.rd_cnt))
    else $error("scan data without a read");

endmodule

### src/ptpm_ctrl.sv
// controller state machine: sequences add, scan, read/write-back and result
// depends on ptpm_pkg
module ptpm_ctrl
  import ptpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ptpm_sts_t sts,
  output ptpm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_DRAIN,
    S_READ,
    S_DATA,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_tready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.accept = 1'b1;
          case (sts.in_op)
            OP_ADD:                 state_nxt = S_ADD;
            OP_PROMOTE, OP_GET:     state_nxt = sts.in_live ? S_READ : S_DONE;
            OP_POP_MAX, OP_GET_MAX: state_nxt = S_SCAN;
            default:                state_nxt = S_DONE;
          endcase
        end
      end
      S_ADD: begin
        if (sts.cnt_free) begin
          cmd.add_take = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.cnt_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.rd_cnt  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_DRAIN;
        end
      end
      // last scan entry is compared in this cycle
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.rd_h  = 1'b1;
        state_nxt = S_DATA;
      end
      S_DATA: begin
        cmd.grab    = 1'b1;
        cmd.prom_wr = (sts.op == OP_PROMOTE);
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = in_tready_r && (state_r == S_IDLE);

endmodule

### src/priority_table_promote_pop_max_top.sv
// top level of the priority table with promote and pop-max
// depends on ptpm_pkg, ptpm_ctrl and ptpm_dp (which holds ptpm_ram)
//
//  channel  dir   tdata bits (lowest first)                              tuser / tlast
//  in_      in    opcode[2:0] handle[8:3] payload[40:9], pad to 48        none
//  out_     out   status[1:0] handle_out[7:2] payload_out[39:8]           none
//                 priority_out[55:40] is_valid[56], pad to 64
//
// one item at a time; add walks the valid bits for a free slot, pop-max and
// get-max scan every slot with one ram read per slot, promote and get read
// the entry at the handle (promote also writes it back), skipping the read
// for a handle that is not live.
// reset clears all valid bits and the sequence counter; table entries are
// only used behind a set valid bit.
// a new item is accepted while the previous result still waits in the output
// register; a finished result waits for that register before the next item.
module priority_table_promote_pop_max_top
  import ptpm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // opcode, handle, payload
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status, handle_out, payload_out,
                                             // priority_out, is_valid
);

  ptpm_cmd_t cmd;
  ptpm_sts_t sts;

  ptpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptpm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
